// File: rtl/core/jpeg_coefficient_rle_decode_assert.svh
// assertion macros used by the coefficient decoder datapath
// depends on nothing; taken in by `include where assertions are written
`ifndef JPEG_COEFFICIENT_RLE_DECODE_ASSERT_SVH
`define JPEG_COEFFICIENT_RLE_DECODE_ASSERT_SVH

`ifndef ASSERT_OFF
// clocked check, off while reset is held
`define JCRD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("jcrd assertion failed");
// clocked check, also live across reset
`define JCRD_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("jcrd reset assertion failed");
`else
`define JCRD_ASSERT(label, clk, rst_n, prop)
`define JCRD_ASSERT_RST(label, clk, prop)
`endif

`endif

// File: rtl/core/jcrd_pkg.sv
// types, codes and the magnitude decode function of the coefficient decoder
// depends on nothing; used by the top level, the controller and the datapath
package jcrd_pkg;

  localparam int unsigned BlockCoeffs = 64;
  localparam logic [5:0]  LastCoef    = 6'(BlockCoeffs - 1);
  localparam logic [7:0]  SymEob      = 8'h00;
  localparam logic [7:0]  SymZrl      = 8'hF0;
  localparam logic [6:0]  ZrlLen      = 7'd16;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_CLAMP = 2'd2
  } coef_status_t;

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_free;
    logic final_item;
  } sts_t;

  // jpeg magnitude rule: size raw bits to a signed value, size 0 gives 0
  function automatic logic [15:0] magnitude_value(logic [3:0] size, logic [14:0] bits);
    logic [15:0] full;
    logic [15:0] v;
    logic [15:0] top;
    full = (16'd1 << size) - 16'd1;
    v    = {1'b0, bits} & full;
    top  = full ^ (full >> 1);
    if (size == 4'd0) begin
      return 16'd0;
    end else if ((v & top) == 16'd0) begin
      return v - full;
    end else begin
      return v;
    end
  endfunction

endpackage

// File: rtl/core/jcrd_in_if.sv
// symbol channel: valid/ready handshake with component, symbol and extra bits
// depends on nothing
interface jcrd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  component;
  logic [7:0]  symbol;
  logic [14:0] extra_bits;

  modport source (output valid, output component, output symbol, output extra_bits,
                  input ready);
  modport sink (input valid, input component, input symbol, input extra_bits,
                output ready);
endinterface

// File: rtl/core/jcrd_out_if.sv
// coefficient channel: valid/ready handshake with one coefficient per transfer
// depends on nothing
interface jcrd_out_if;
  logic              valid;
  logic              ready;
  logic [5:0]        coef_index;
  logic signed [15:0] coef_value;
  logic [1:0]        out_component;
  logic [1:0]        status;
  logic              last_of_item;
  logic              block_done;

  modport source (output valid, output coef_index, output coef_value,
                  output out_component, output status, output last_of_item,
                  output block_done, input ready);
  modport sink (input valid, input coef_index, input coef_value,
                input out_component, input status, input last_of_item,
                input block_done, output ready);
endinterface

// File: rtl/core/jpeg_coefficient_rle_decode.sv
// top level of the jpeg baseline dc/ac coefficient decoder
// depends on jcrd_pkg, jcrd_in_if, jcrd_out_if, jcrd_ctrl and jcrd_datapath
//
//  channel   dir  handshake    payload
//  in_chan   in   valid/ready  component, symbol, extra_bits
//  out_chan  out  valid/ready  coef_index, coef_value, out_component, status,
//                              last_of_item, block_done
//
// a symbol is taken, then its n results leave one per cycle while the output is not stalled,
// stepped by the single result counter feeding the output register
// a dc symbol or an invalid code gives one result; eob and runs give up to 63
// out_ready low with a result held freezes the output register and the counter; no symbol is taken
// until the last result of the current one is in the output register
// reset (synchronous, active low) zeroes the block position and all dc predictors at once
module jpeg_coefficient_rle_decode #(
  parameter int COMPONENT_COUNT = 3
) (
  input  logic clk,
  input  logic rst_n,
  jcrd_in_if.sink    in_chan,
  jcrd_out_if.source out_chan
);

  // command and status between controller and datapath
  jcrd_pkg::cmd_t cmd;
  jcrd_pkg::sts_t sts;

  // controller: idle takes a symbol, emit steps through its results
  jcrd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: plans the run on accept, commits position and predictor,
  // then feeds the output register one coefficient at a time
  jcrd_datapath #(
    .COMPONENT_COUNT (COMPONENT_COUNT)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_component      (in_chan.component),
    .in_symbol         (in_chan.symbol),
    .in_extra_bits     (in_chan.extra_bits),
    .out_ready         (out_chan.ready),
    .out_valid         (out_chan.valid),
    .out_coef_index    (out_chan.coef_index),
    .out_coef_value    (out_chan.coef_value),
    .out_out_component (out_chan.out_component),
    .out_status        (out_chan.status),
    .out_last_of_item  (out_chan.last_of_item),
    .out_block_done    (out_chan.block_done)
  );

endmodule

// File: rtl/core/jcrd_ctrl.sv
// controller of the coefficient decoder: takes a symbol, then steps out its results
// depends on jcrd_pkg
module jcrd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  jcrd_pkg::sts_t sts,
  output jcrd_pkg::cmd_t cmd
);

  jcrd_pkg::state_t state_r;
  jcrd_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jcrd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      jcrd_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = jcrd_pkg::S_EMIT;
        end
      end
      jcrd_pkg::S_EMIT: begin
        if (sts.slot_free && sts.final_item) begin
          state_nxt = jcrd_pkg::S_IDLE;
        end
      end
      default: state_nxt = jcrd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      jcrd_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      jcrd_pkg::S_EMIT: begin
        cmd.emit = sts.slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/core/jcrd_datapath.sv
// datapath of the coefficient decoder: block position, dc predictors,
// per-symbol run plan, result counter and output register
// depends on jcrd_pkg and jpeg_coefficient_rle_decode_assert.svh
`include "jpeg_coefficient_rle_decode_assert.svh"

module jcrd_datapath #(
  parameter int COMPONENT_COUNT = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  jcrd_pkg::cmd_t     cmd,
  output jcrd_pkg::sts_t     sts,
  input  logic [1:0]         in_component,
  input  logic [7:0]         in_symbol,
  input  logic [14:0]        in_extra_bits,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [5:0]         out_coef_index,
  output logic signed [15:0] out_coef_value,
  output logic [1:0]         out_out_component,
  output logic [1:0]         out_status,
  output logic               out_last_of_item,
  output logic               out_block_done
);

  localparam int         CompIdxW = (COMPONENT_COUNT > 1) ? $clog2(COMPONENT_COUNT) : 1;
  localparam logic [2:0] CompCnt  = 3'(COMPONENT_COUNT);
  localparam logic [1:0] CompMax  = 2'(COMPONENT_COUNT - 1);

  // block state
  logic [5:0]  pos_r;
  logic [1:0]  blk_comp_r;
  logic [15:0] pred_r [COMPONENT_COUNT];

  // plan of the symbol being emitted
  logic [5:0]                 idx_r;
  logic [5:0]                 last_idx_r;
  logic [15:0]                val_r;
  jcrd_pkg::coef_status_t     st_r;
  logic                       done_en_r;

  // output register
  logic                       oval_r;
  logic [5:0]                 oidx_r;
  logic [15:0]                oval_data_r;
  logic [1:0]                 ocomp_r;
  jcrd_pkg::coef_status_t     ost_r;
  logic                       olast_r;
  logic                       odone_r;

  logic [1:0]             comp_c;
  logic [CompIdxW-1:0]    comp_idx;
  logic [3:0]             run_c;
  logic [3:0]             size_c;
  logic [15:0]            mag_c;
  logic [15:0]            dc_sum_c;
  logic [6:0]             zrl_end_c;
  logic [6:0]             run_end_c;

  logic [5:0]             last_nxt;
  logic [15:0]            val_nxt;
  jcrd_pkg::coef_status_t st_nxt;
  logic                   done_en_nxt;
  logic [5:0]             pos_nxt;
  logic                   pred_we;

  assign comp_c    = ({1'b0, in_component} >= CompCnt) ? CompMax : in_component;
  assign comp_idx  = comp_c[CompIdxW-1:0];
  assign run_c     = in_symbol[7:4];
  assign size_c    = in_symbol[3:0];
  assign mag_c     = jcrd_pkg::magnitude_value(size_c, in_extra_bits);
  assign dc_sum_c  = pred_r[comp_idx] + mag_c;
  assign zrl_end_c = {1'b0, pos_r} + jcrd_pkg::ZrlLen;
  assign run_end_c = {1'b0, pos_r} + {3'b000, run_c};

  always_comb begin
    last_nxt    = pos_r;
    val_nxt     = 16'd0;
    st_nxt      = jcrd_pkg::ST_OK;
    done_en_nxt = 1'b0;
    pos_nxt     = pos_r;
    pred_we     = 1'b0;
    priority if (pos_r == 6'd0) begin
      if (run_c != 4'd0) begin
        st_nxt = jcrd_pkg::ST_BAD;
      end else begin
        val_nxt = dc_sum_c;
        pred_we = 1'b1;
        pos_nxt = 6'd1;
      end
    end else if (in_symbol == jcrd_pkg::SymEob) begin
      last_nxt    = jcrd_pkg::LastCoef;
      done_en_nxt = 1'b1;
      pos_nxt     = 6'd0;
    end else if (in_symbol == jcrd_pkg::SymZrl) begin
      done_en_nxt = 1'b1;
      if (zrl_end_c > 7'(jcrd_pkg::BlockCoeffs)) begin
        last_nxt = jcrd_pkg::LastCoef;
        st_nxt   = jcrd_pkg::ST_CLAMP;
        pos_nxt  = 6'd0;
      end else begin
        last_nxt = 6'(zrl_end_c - 7'd1);
        pos_nxt  = zrl_end_c[5:0];
      end
    end else if (size_c == 4'd0) begin
      st_nxt = jcrd_pkg::ST_BAD;
    end else if (run_end_c > {1'b0, jcrd_pkg::LastCoef}) begin
      last_nxt    = jcrd_pkg::LastCoef;
      st_nxt      = jcrd_pkg::ST_CLAMP;
      done_en_nxt = 1'b1;
      pos_nxt     = 6'd0;
    end else begin
      last_nxt    = run_end_c[5:0];
      val_nxt     = mag_c;
      done_en_nxt = 1'b1;
      pos_nxt     = 6'(run_end_c + 7'd1);
    end
  end

  // block state, committed when the symbol is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= 6'd0;
      blk_comp_r <= 2'd0;
      for (int i = 0; i < COMPONENT_COUNT; i++) begin
        pred_r[i] <= 16'd0;
      end
    end else if (cmd.load) begin
      pos_r <= pos_nxt;
      if (pred_we) begin
        blk_comp_r <= comp_c;
        for (int i = 0; i < COMPONENT_COUNT; i++) begin
          if (comp_idx == CompIdxW'(i)) begin
            pred_r[i] <= dc_sum_c;
          end
        end
      end
    end
  end

  // run plan and result counter
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r      <= pos_r;
      last_idx_r <= last_nxt;
      val_r      <= val_nxt;
      st_r       <= st_nxt;
      done_en_r  <= done_en_nxt;
    end else if (cmd.emit) begin
      idx_r <= idx_r + 6'd1;
    end
  end

  assign sts.final_item = (idx_r == last_idx_r);
  assign sts.slot_free  = !oval_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oval_r <= 1'b0;
    end else if (cmd.emit) begin
      oval_r <= 1'b1;
    end else if (out_ready) begin
      oval_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      oidx_r      <= idx_r;
      oval_data_r <= sts.final_item ? val_r : 16'd0;
      ocomp_r     <= blk_comp_r;
      ost_r       <= st_r;
      olast_r     <= sts.final_item;
      odone_r     <= sts.final_item && done_en_r && (idx_r == jcrd_pkg::LastCoef);
    end
  end

  assign out_valid         = oval_r;
  assign out_coef_index    = oidx_r;
  assign out_coef_value    = oval_data_r;
  assign out_out_component = ocomp_r;
  assign out_status        = ost_r;
  assign out_last_of_item  = olast_r;
  assign out_block_done    = odone_r;

  `JCRD_ASSERT(a_done_at_end, clk, rst_n, oval_r && odone_r |-> oidx_r == jcrd_pkg::LastCoef && olast_r)
  `JCRD_ASSERT(a_bad_is_single, clk, rst_n, oval_r && ost_r == jcrd_pkg::ST_BAD |-> oval_data_r == 16'd0 && olast_r && !odone_r)
  `JCRD_ASSERT(a_clamp_zero, clk, rst_n, oval_r && ost_r == jcrd_pkg::ST_CLAMP |-> oval_data_r == 16'd0)
  `JCRD_ASSERT(a_run_steps, clk, rst_n, cmd.emit && !sts.final_item |=> idx_r == $past(idx_r) + 6'd1)
  `JCRD_ASSERT_RST(a_reset_empty, clk, !rst_n |=> !oval_r)

endmodule
